// File: design/pwtc_pkg.sv
`timescale 1ns / 1ps

package pwtc_pkg;

    localparam int NumTaps = 9;

    // Input transaction: nine window pixels and the in-image mask.
    typedef struct packed {
        logic [23:0] pixel_0;
        logic [23:0] pixel_1;
        logic [23:0] pixel_2;
        logic [23:0] pixel_3;
        logic [23:0] pixel_4;
        logic [23:0] pixel_5;
        logic [23:0] pixel_6;
        logic [23:0] pixel_7;
        logic [23:0] pixel_8;
        logic [8:0]  sample_mask;
    } win_item_t;

    // Output transaction: one character cell.
    typedef struct packed {
        logic       blank_cell;
        logic [1:0] shade_index;
        logic [7:0] gray_level;
        logic       color_valid;
        logic [6:0] ansi_code;
    } text_item_t;

    // Per-stage load enables of the pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

    localparam int SumW  = 12;   // 9 * 255 fits in 12 bits
    localparam int CntW  = 4;    // 0 .. 9 samples
    localparam int RecW  = 17;   // ceil(2^16 / d)
    localparam int RecSh = 16;

    // ceil(2^16 / d) for d = 1..9; exact floor division for sums below 2^12.
    function automatic logic [RecW-1:0] lane_recip(input logic [CntW-1:0] d);
        logic [RecW-1:0] m;
        begin
            unique case (d)
                4'd1:    m = 17'd65536;
                4'd2:    m = 17'd32768;
                4'd3:    m = 17'd21846;
                4'd4:    m = 17'd16384;
                4'd5:    m = 17'd13108;
                4'd6:    m = 17'd10923;
                4'd7:    m = 17'd9363;
                4'd8:    m = 17'd8192;
                4'd9:    m = 17'd7282;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

    // Luma weights and the reciprocal of 1000 (shift 28).
    localparam logic [17:0] LumaR = 18'd299;
    localparam logic [17:0] LumaG = 18'd587;
    localparam logic [17:0] LumaB = 18'd114;
    localparam logic [36:0] GrayRecip = 37'd268436;
    localparam int          GraySh    = 28;

    // Shade boundaries on the weighted sum (gray 85, 170, 255 times 1000).
    localparam logic [17:0] Shade1Min = 18'd85000;
    localparam logic [17:0] Shade2Min = 18'd170000;
    localparam logic [17:0] Shade3Min = 18'd255000;

    // Reciprocal of 3 (shift 12) for brightness.
    localparam logic [20:0] BrRecip = 21'd1366;
    localparam int          BrSh    = 12;

    // Colour thresholds.
    localparam logic [7:0] SatMin    = 8'd30;
    localparam logic [7:0] LvlHigh   = 8'd200;
    localparam logic [7:0] LvlMid    = 8'd150;
    localparam logic [7:0] LvlLow    = 8'd50;
    localparam logic [7:0] LvlBright = 8'd180;
    localparam logic [7:0] ChanHigh  = 8'd150;
    localparam logic [7:0] ChanLow   = 8'd100;
    localparam logic [7:0] ChanWhite = 8'd120;

    // SGR foreground codes.
    localparam logic [6:0] AnsiNone      = 7'd0;
    localparam logic [6:0] AnsiBlack     = 7'd30;
    localparam logic [6:0] AnsiRed       = 7'd31;
    localparam logic [6:0] AnsiGreen     = 7'd32;
    localparam logic [6:0] AnsiBlue      = 7'd34;
    localparam logic [6:0] AnsiWhite     = 7'd37;
    localparam logic [6:0] AnsiGray      = 7'd90;
    localparam logic [6:0] AnsiBrRed     = 7'd91;
    localparam logic [6:0] AnsiBrGreen   = 7'd92;
    localparam logic [6:0] AnsiBrYellow  = 7'd93;
    localparam logic [6:0] AnsiBrBlue    = 7'd94;
    localparam logic [6:0] AnsiBrMagenta = 7'd95;
    localparam logic [6:0] AnsiBrCyan    = 7'd96;
    localparam logic [6:0] AnsiBrWhite   = 7'd97;

    // Register map.
    localparam logic RegColorEnable = 1'b0;

endpackage

// File: design/pwtc_lane.sv
`timescale 1ns / 1ps

module pwtc_lane
    import pwtc_pkg::*;
(
    input  logic                        clk,
    input  pipe_en_t                    en,
    input  logic [NumTaps-1:0][7:0]     samp,
    input  logic [NumTaps-1:0]          mask,
    input  logic [CntW-1:0]             cnt,
    output logic [7:0]                  mean
);

    logic [SumW-1:0]      sum_next;
    logic [SumW-1:0]      sum_reg;
    logic [SumW+RecW-1:0] quot_prod;
    logic [7:0]           mean_next;
    logic [7:0]           mean_reg;

    // Sum the masked samples of this channel.
    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NumTaps; k++)
        begin
            if (mask[k])
            begin
                sum_next = sum_next + SumW'(samp[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            sum_reg <= sum_next;
        end
    end

    // Divide by the sample count through its reciprocal.
    assign quot_prod = (SumW+RecW)'(sum_reg) * (SumW+RecW)'(lane_recip(cnt));
    assign mean_next = quot_prod[RecSh+7:RecSh];

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            mean_reg <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule

// File: design/pwtc_merge.sv
`timescale 1ns / 1ps

module pwtc_merge
    import pwtc_pkg::*;
(
    input  logic       clk,
    input  pipe_en_t   en,
    input  logic       blank,
    input  logic [7:0] mean_r,
    input  logic [7:0] mean_g,
    input  logic [7:0] mean_b,
    input  logic       color_enable,
    output text_item_t result
);

    logic [17:0] wsum_next;
    logic [9:0]  bsum;
    logic [20:0] br_prod;
    logic [7:0]  mx;
    logic [7:0]  mn;

    logic [17:0] wsum_reg;
    logic [7:0]  br_reg;
    logic [7:0]  r_reg;
    logic [7:0]  g_reg;
    logic [7:0]  b_reg;
    logic        sat_low_reg;
    logic        blank_reg;

    logic [36:0] gray_prod;
    logic [7:0]  gray;
    logic [1:0]  shade;
    logic [6:0]  code;
    text_item_t  result_next;
    text_item_t  result_reg;

    // Weighted luma sum, brightness and saturation of the mean colour.
    assign wsum_next = 18'(mean_r) * LumaR + 18'(mean_g) * LumaG + 18'(mean_b) * LumaB;
    assign bsum      = 10'(mean_r) + 10'(mean_g) + 10'(mean_b);
    assign br_prod   = 21'(bsum) * BrRecip;

    always_comb
    begin
        mx = mean_r;
        mn = mean_r;
        if (mean_g > mx) mx = mean_g;
        if (mean_b > mx) mx = mean_b;
        if (mean_g < mn) mn = mean_g;
        if (mean_b < mn) mn = mean_b;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            wsum_reg    <= wsum_next;
            br_reg      <= br_prod[BrSh+7:BrSh];
            r_reg       <= mean_r;
            g_reg       <= mean_g;
            b_reg       <= mean_b;
            sat_low_reg <= (mx - mn) < SatMin;
            blank_reg   <= blank;
        end
    end

    // Gray level is the weighted sum over 1000; shade boundaries sit on the sum.
    assign gray_prod = 37'(wsum_reg) * GrayRecip;
    assign gray      = gray_prod[GraySh+7:GraySh];

    always_comb
    begin
        priority if (wsum_reg >= Shade3Min) shade = 2'd3;
        else if (wsum_reg >= Shade2Min)     shade = 2'd2;
        else if (wsum_reg >= Shade1Min)     shade = 2'd1;
        else                                shade = 2'd0;
    end

    function automatic logic [6:0] ladder(input logic [7:0] br);
        logic [6:0] c;
        begin
            priority if (br > LvlHigh) c = AnsiBrWhite;
            else if (br > LvlMid)      c = AnsiWhite;
            else if (br > LvlLow)      c = AnsiGray;
            else                       c = AnsiBlack;
            return c;
        end
    endfunction

    always_comb
    begin
        priority if (sat_low_reg)
            code = ladder(br_reg);
        else if (r_reg > g_reg && r_reg > b_reg)
            code = (br_reg > LvlBright) ? AnsiBrRed : AnsiRed;
        else if (g_reg > r_reg && g_reg > b_reg)
            code = (br_reg > LvlBright) ? AnsiBrGreen : AnsiGreen;
        else if (b_reg > r_reg && b_reg > g_reg)
            code = (br_reg > LvlBright) ? AnsiBrBlue : AnsiBlue;
        else if (r_reg > ChanHigh && g_reg > ChanHigh && b_reg < ChanLow)
            code = AnsiBrYellow;
        else if (r_reg > ChanHigh && g_reg < ChanLow && b_reg > ChanHigh)
            code = AnsiBrMagenta;
        else if (r_reg < ChanLow && g_reg > ChanHigh && b_reg > ChanHigh)
            code = AnsiBrCyan;
        else if (r_reg > ChanWhite && g_reg > ChanWhite && b_reg > ChanWhite)
            code = (br_reg > LvlHigh) ? AnsiBrWhite : AnsiWhite;
        else
            code = ladder(br_reg);
    end

    always_comb
    begin
        if (blank_reg)
        begin
            result_next.blank_cell  = 1'b1;
            result_next.shade_index = '0;
            result_next.gray_level  = '0;
            result_next.color_valid = 1'b0;
            result_next.ansi_code   = AnsiNone;
        end
        else
        begin
            result_next.blank_cell  = 1'b0;
            result_next.shade_index = shade;
            result_next.gray_level  = gray;
            result_next.color_valid = color_enable;
            result_next.ansi_code   = color_enable ? code : AnsiNone;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: design/pixel_window_to_text_cell_core.sv
`timescale 1ns / 1ps
// An accepted window transaction reaches its cell on txt_data through the registers below.
// Throughput: one transaction per cycle unless stalled; four pipeline registers (lane sum, lane
//   divide, luma/brightness, cell output) each hold one transaction at a time.
// Reset: rst_n clears all valid flags and sets color_enable to 1; no clearing pass.

module pixel_window_to_text_cell_core
    import pwtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Window stream
    input  logic        win_valid,
    output logic        win_stall,
    input  win_item_t   win_data,

    // Cell stream
    output logic        txt_valid,
    input  logic        txt_stall,
    output text_item_t  txt_data,

    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic                    rdy1, rdy2, rdy3, rdy4;
    pipe_en_t                pen;

    logic [NumTaps-1:0][23:0] pix;
    logic [NumTaps-1:0][7:0]  samp_r, samp_g, samp_b;
    logic [NumTaps-1:0]       mask;
    logic [CntW-1:0]          cnt_next;
    logic [CntW-1:0]          cnt_reg;
    logic                     blank_reg;
    logic [7:0]               mean_r, mean_g, mean_b;

    logic                     color_enable_reg;
    logic                     cfg_wr;

    // ------------------------------------------------------------------
    // Pipeline control: each stage takes a new transaction when it is
    // empty or its contents move on, so bubbles collapse; while a finished
    // cell waits at the output, input flows until every stage is full.
    // ------------------------------------------------------------------
    assign rdy4 = !v4_reg || !txt_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign pen.s1 = rdy1 && win_valid;
    assign pen.s2 = rdy2 && v1_reg;
    assign pen.s3 = rdy3 && v2_reg;
    assign pen.s4 = rdy4 && v3_reg;

    assign win_stall = !rdy1;
    assign txt_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= win_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Split the window into per-channel sample rows and count the
    // samples inside the image.
    // ------------------------------------------------------------------
    assign pix[0] = win_data.pixel_0;
    assign pix[1] = win_data.pixel_1;
    assign pix[2] = win_data.pixel_2;
    assign pix[3] = win_data.pixel_3;
    assign pix[4] = win_data.pixel_4;
    assign pix[5] = win_data.pixel_5;
    assign pix[6] = win_data.pixel_6;
    assign pix[7] = win_data.pixel_7;
    assign pix[8] = win_data.pixel_8;
    assign mask   = win_data.sample_mask;

    always_comb
    begin
        cnt_next = '0;
        for (int k = 0; k < NumTaps; k++)
        begin
            samp_r[k] = pix[k][23:16];
            samp_g[k] = pix[k][15:8];
            samp_b[k] = pix[k][7:0];
            cnt_next  = cnt_next + CntW'(mask[k]);
        end
    end

    // Hold the count beside the lane sums, then the empty flag beside the means.
    always_ff @(posedge clk)
    begin
        if (pen.s1)
        begin
            cnt_reg <= cnt_next;
        end
        if (pen.s2)
        begin
            blank_reg <= (cnt_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // One lane per colour channel: masked sum, then divide by count.
    // ------------------------------------------------------------------
    pwtc_lane u_lane_r
    (
        .clk  (clk),
        .en   (pen),
        .samp (samp_r),
        .mask (mask),
        .cnt  (cnt_reg),
        .mean (mean_r)
    );

    pwtc_lane u_lane_g
    (
        .clk  (clk),
        .en   (pen),
        .samp (samp_g),
        .mask (mask),
        .cnt  (cnt_reg),
        .mean (mean_g)
    );

    pwtc_lane u_lane_b
    (
        .clk  (clk),
        .en   (pen),
        .samp (samp_b),
        .mask (mask),
        .cnt  (cnt_reg),
        .mean (mean_b)
    );

    // ------------------------------------------------------------------
    // Merge the channel means into gray level, shade and colour code.
    // ------------------------------------------------------------------
    pwtc_merge u_merge
    (
        .clk          (clk),
        .en           (pen),
        .blank        (blank_reg),
        .mean_r       (mean_r),
        .mean_g       (mean_g),
        .mean_b       (mean_b),
        .color_enable (color_enable_reg),
        .result       (txt_data)
    );

    // ------------------------------------------------------------------
    // Register port: color_enable at byte address 0; other words drop
    // writes and read as zero.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_enable_reg <= 1'b1;
        end
        else if (cfg_wr && (paddr[2] == RegColorEnable))
        begin
            color_enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == RegColorEnable) ? {31'd0, color_enable_reg} : 32'd0;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pwtc_pkg::*;

    // Four pipeline registers between window and cell.
    localparam int PipeLatency = 4;
    localparam int CycleLimit  = 500000;

    // Byte address of the colour switch, and the first address past the map.
    localparam logic [2:0] ColorEnableAddr = {2'b00, RegColorEnable} << 2;
    localparam logic [2:0] UnusedAddr      = ColorEnableAddr + 3'd4;

    // Scoreboard: predicts one text cell per accepted window transaction and
    // checks cells against the predictions in order.
    class cell_scoreboard;
        bit          color_on;
        text_item_t  pending_cells[$];
        int unsigned fails;

        function new();
            color_on = 1'b1;
            fails = 0;
        endfunction

        function logic [6:0] brightness_code(int unsigned br);
            if (br > LvlHigh) return AnsiBrWhite;
            if (br > LvlMid) return AnsiWhite;
            if (br > LvlLow) return AnsiGray;
            return AnsiBlack;
        endfunction

        function logic [6:0] sgr_code(int unsigned r, int unsigned g, int unsigned b);
            int unsigned br;
            int unsigned hi;
            int unsigned lo;
            br = (r + g + b) / 3;
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            if (hi - lo < SatMin) return brightness_code(br);
            if (r > g && r > b) return (br > LvlBright) ? AnsiBrRed : AnsiRed;
            if (g > r && g > b) return (br > LvlBright) ? AnsiBrGreen : AnsiGreen;
            if (b > r && b > g) return (br > LvlBright) ? AnsiBrBlue : AnsiBlue;
            if (r > ChanHigh && g > ChanHigh && b < ChanLow) return AnsiBrYellow;
            if (r > ChanHigh && g < ChanLow && b > ChanHigh) return AnsiBrMagenta;
            if (r < ChanLow && g > ChanHigh && b > ChanHigh) return AnsiBrCyan;
            if (r > ChanWhite && g > ChanWhite && b > ChanWhite)
                return (br > LvlHigh) ? AnsiBrWhite : AnsiWhite;
            return brightness_code(br);
        endfunction

        function void note_window(win_item_t w);
            logic [23:0] px [NumTaps];
            int unsigned rsum;
            int unsigned gsum;
            int unsigned bsum;
            int unsigned taps;
            int unsigned r;
            int unsigned g;
            int unsigned b;
            int unsigned gray;
            int unsigned shade;
            text_item_t  pred;
            px[0] = w.pixel_0;
            px[1] = w.pixel_1;
            px[2] = w.pixel_2;
            px[3] = w.pixel_3;
            px[4] = w.pixel_4;
            px[5] = w.pixel_5;
            px[6] = w.pixel_6;
            px[7] = w.pixel_7;
            px[8] = w.pixel_8;
            rsum = 0;
            gsum = 0;
            bsum = 0;
            taps = 0;
            pred = '0;
            for (int k = 0; k < NumTaps; k++)
            begin
                if (w.sample_mask[k])
                begin
                    rsum += px[k][23:16];
                    gsum += px[k][15:8];
                    bsum += px[k][7:0];
                    taps++;
                end
            end
            if (taps == 0)
                pred.blank_cell = 1'b1;
            else
            begin
                r = rsum / taps;
                g = gsum / taps;
                b = bsum / taps;
                gray = (LumaR * r + LumaG * g + LumaB * b) / 1000;
                shade = gray * 3 / 255;
                if (shade > 3) shade = 3;
                pred.gray_level  = gray[7:0];
                pred.shade_index = shade[1:0];
                pred.color_valid = color_on;
                pred.ansi_code   = color_on ? sgr_code(r, g, b) : AnsiNone;
            end
            pending_cells.push_back(pred);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_cell(text_item_t got);
            text_item_t want;
            if (pending_cells.size() == 0)
            begin
                $error("cell transaction with no window outstanding");
                fails++;
                return;
            end
            want = pending_cells.pop_front();
            check_field("blank_cell", want.blank_cell, got.blank_cell);
            check_field("shade_index", want.shade_index, got.shade_index);
            check_field("gray_level", want.gray_level, got.gray_level);
            check_field("color_valid", want.color_valid, got.color_valid);
            check_field("ansi_code", want.ansi_code, got.ansi_code);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        win_valid = 1'b0;
    logic        win_stall;
    win_item_t   win_data = '0;
    logic        txt_valid;
    logic        txt_stall = 1'b0;
    text_item_t  txt_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned    cycles = 0;
    int unsigned    stall_left = 0;
    int unsigned    stall_mode = 0;
    cell_scoreboard sb = new();

    pixel_window_to_text_cell_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_stall (win_stall),
        .win_data  (win_data),
        .txt_valid (txt_valid),
        .txt_stall (txt_stall),
        .txt_data  (txt_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver backpressure: switch at random between these modes:
    // never stall, light random stall, heavy random stall, long stall runs.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        else
            stall_left = stall_left - 1;
        case (stall_mode)
            0: txt_stall <= 1'b0;
            1: txt_stall <= ($urandom_range(0, 99) < 25);
            2: txt_stall <= ($urandom_range(0, 99) < 70);
            default:
            begin
                if ($urandom_range(0, 15) == 0)
                    txt_stall <= ~txt_stall;
            end
        endcase
    end

    // Check every cell transaction; all signals read here are pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n && txt_valid && !txt_stall)
            sb.check_cell(txt_data);
    end

    // Register write: setup phase, then access phase until pready.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ColorEnableAddr)
            sb.color_on = data[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Read the colour switch back and compare it with the scoreboard's copy.
    task automatic check_register();
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ColorEnableAddr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        want = {31'b0, sb.color_on};
        if (prdata !== want)
        begin
            $error("color_enable expected %0d, got %0d", want, prdata);
            sb.fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Present one window transaction and hold it until accepted.
    task automatic send_window(input win_item_t w);
        win_valid <= 1'b1;
        win_data  <= w;
        do
            @(posedge clk);
        while (win_stall);
        sb.note_window(w);
    endtask

    // Drop valid and idle; n (n >= 1) sets how long.
    task automatic idle(input int unsigned n);
        win_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off until every predicted cell has come out, then let the pipe settle.
    task automatic wait_drained();
        while (sb.pending_cells.size() != 0)
            @(posedge clk);
        repeat (PipeLatency + 4) @(posedge clk);
    endtask

    function automatic win_item_t flat_window(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                              logic [8:0] mask);
        win_item_t w;
        w.pixel_0 = {r, g, b};
        w.pixel_1 = {r, g, b};
        w.pixel_2 = {r, g, b};
        w.pixel_3 = {r, g, b};
        w.pixel_4 = {r, g, b};
        w.pixel_5 = {r, g, b};
        w.pixel_6 = {r, g, b};
        w.pixel_7 = {r, g, b};
        w.pixel_8 = {r, g, b};
        w.sample_mask = mask;
        return w;
    endfunction

    // Channel level biased toward the colour thresholds and the extremes.
    function automatic logic [7:0] pick_level();
        logic [7:0] marks [14] = '{0, 29, 30, 50, 51, 99, 100, 120, 121, 150, 151,
                                   180, 201, 255};
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 60));
            1: return 8'($urandom_range(140, 255));
            2: return marks[$urandom_range(0, 13)];
            default: return 8'($urandom);
        endcase
    endfunction

    // Random window: mostly a base colour with jitter so the mean lands on
    // every colour branch, sometimes fully random pixels.
    function automatic win_item_t random_window();
        win_item_t   w;
        logic [23:0] px [NumTaps];
        logic [7:0]  base [3];
        int          jit;
        int          v;
        int unsigned pick;
        if ($urandom_range(0, 9) < 2)
        begin
            foreach (px[k])
                px[k] = 24'($urandom);
        end
        else
        begin
            foreach (base[c])
                base[c] = pick_level();
            // Tie two channels so the non-dominant tests get exercised.
            if ($urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, 2);
                base[pick] = base[(pick + 1) % 3];
            end
            jit = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 24));
            foreach (px[k])
            begin
                for (int c = 0; c < 3; c++)
                begin
                    v = int'(base[c]) + int'($urandom_range(0, 2 * jit)) - jit;
                    if (v < 0) v = 0;
                    else if (v > 255) v = 255;
                    px[k][8 * (2 - c) +: 8] = v[7:0];
                end
            end
        end
        w.pixel_0 = px[0];
        w.pixel_1 = px[1];
        w.pixel_2 = px[2];
        w.pixel_3 = px[3];
        w.pixel_4 = px[4];
        w.pixel_5 = px[5];
        w.pixel_6 = px[6];
        w.pixel_7 = px[7];
        w.pixel_8 = px[8];
        case ($urandom_range(0, 9))
            0: w.sample_mask = '0;
            1, 2: w.sample_mask = '1;
            default: w.sample_mask = 9'($urandom);
        endcase
        return w;
    endfunction

    // Directed windows: extremes, empty mask, each colour branch, truncation.
    task automatic run_directed();
        win_item_t cases[$];
        win_item_t w;
        cases.push_back(flat_window(8'd0, 8'd0, 8'd0, '1));
        cases.push_back(flat_window(8'd255, 8'd255, 8'd255, '1));
        cases.push_back(flat_window(8'd255, 8'd255, 8'd255, '0));
        cases.push_back(flat_window(8'd180, 8'd180, 8'd180, '1));
        cases.push_back(flat_window(8'd100, 8'd100, 8'd100, '1));
        cases.push_back(flat_window(8'd220, 8'd40, 8'd40, '1));
        cases.push_back(flat_window(8'd255, 8'd200, 8'd200, '1));
        cases.push_back(flat_window(8'd40, 8'd200, 8'd40, '1));
        cases.push_back(flat_window(8'd200, 8'd255, 8'd200, '1));
        cases.push_back(flat_window(8'd40, 8'd40, 8'd200, '1));
        cases.push_back(flat_window(8'd200, 8'd200, 8'd255, '1));
        cases.push_back(flat_window(8'd200, 8'd200, 8'd50, '1));
        cases.push_back(flat_window(8'd200, 8'd50, 8'd200, '1));
        cases.push_back(flat_window(8'd50, 8'd200, 8'd200, '1));
        cases.push_back(flat_window(8'd160, 8'd160, 8'd130, '1));
        cases.push_back(flat_window(8'd250, 8'd250, 8'd210, '1));
        // Neither dominant nor a named mix: falls back to the brightness ladder.
        cases.push_back(flat_window(8'd100, 8'd100, 8'd50, '1));
        cases.push_back(flat_window(8'd60, 8'd60, 8'd0, '1));
        // Only the centre tap inside the image.
        w = flat_window(8'd255, 8'd255, 8'd255, 9'b0_0001_0000);
        w.pixel_4 = 24'hFF0000;
        cases.push_back(w);
        // Only the bottom-right tap inside the image.
        w = flat_window(8'd0, 8'd0, 8'd0, 9'b1_0000_0000);
        w.pixel_8 = 24'h00FF80;
        cases.push_back(w);
        // Checkerboard of black and white over the full window.
        w = flat_window(8'd255, 8'd255, 8'd255, '1);
        w.pixel_1 = 24'h000000;
        w.pixel_3 = 24'h000000;
        w.pixel_5 = 24'h000000;
        w.pixel_7 = 24'h000000;
        cases.push_back(w);
        // Two taps whose sums do not divide evenly.
        w = flat_window(8'd1, 8'd1, 8'd1, 9'b0_0000_0011);
        w.pixel_1 = 24'h020202;
        cases.push_back(w);
        foreach (cases[i])
            send_window(cases[i]);
        idle(1);
    endtask

    // Random windows in bursts; now and then drain the pipe completely.
    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_window(random_window());
                sent++;
            end
            idle($urandom_range(1, 8));
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Colour on from reset.
        check_register();
        run_directed();
        wait_drained();

        // Colour off: shade only.
        write_register(ColorEnableAddr, 32'h0000_0000);
        check_register();
        run_directed();
        wait_drained();

        // A write outside the register map must leave the switch alone.
        write_register(UnusedAddr, 32'hFFFF_FFFF);
        check_register();
        run_random(100);
        wait_drained();

        // Only bit 0 of the write data counts.
        write_register(ColorEnableAddr, 32'hFFFF_FFFF);
        check_register();
        run_random(600);
        wait_drained();

        write_register(ColorEnableAddr, 32'hFFFF_FFFE);
        check_register();
        run_random(400);
        wait_drained();

        write_register(ColorEnableAddr, 32'h0000_0001);
        check_register();
        run_random(500);
        wait_drained();

        if (sb.fails == 0 && sb.pending_cells.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
